[rtl/ppid_pkg.sv]
// Shared types, constants and the microcode program of the positional PID block.
// Depends on nothing; used by every module in rtl/.
`default_nettype none

package ppid_pkg;

	localparam int StepW = 5;
	typedef logic [StepW-1:0] step_t;

	localparam int RegIdxW = 3;
	localparam int CfgDataW = 47;
	typedef logic [RegIdxW-1:0] reg_idx_t;

	localparam reg_idx_t RegGainP = 3'd0;
	localparam reg_idx_t RegGainI = 3'd1;
	localparam reg_idx_t RegGainD = 3'd2;
	localparam reg_idx_t RegPeriod = 3'd3;
	localparam reg_idx_t RegRate = 3'd4;
	localparam reg_idx_t RegDriveMin = 3'd5;
	localparam reg_idx_t RegDriveMax = 3'd6;
	localparam reg_idx_t RegIntBound = 3'd7;

	// Reset value of the integral limit: 100000.0 in Q31.16.
	localparam logic [CfgDataW-1:0] IntBoundReset = 47'd6553600000;
	localparam logic [31:0] DriveMinReset = 32'h8000_0000;
	localparam logic [31:0] DriveMaxReset = 32'h7FFF_FFFF;

	// Saturation level of one gain term, 2^60.
	localparam logic [65:0] TermLimit = 66'd1 << 60;

	typedef struct packed {
		logic [31:0] gain_p;
		logic [31:0] gain_i;
		logic [31:0] gain_d;
		logic [31:0] period;
		logic [31:0] rate;
		logic [31:0] drive_min;
		logic [31:0] drive_max;
		logic [CfgDataW-1:0] bound;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ERR,
		OP_DIFF,
		OP_MUL_DR,
		OP_DERIV,
		OP_MUL_EP,
		OP_CAND,
		OP_MLO,
		OP_MHI,
		OP_ACC,
		OP_HOLD,
		OP_OUT,
		OP_CLR,
		OP_DIS
	} op_t;

	typedef enum logic [1:0] {
		TS_P,
		TS_I_CAND,
		TS_I_OLD,
		TS_D
	} tsel_t;

	typedef enum logic [1:0] {
		BS_ZERO,
		BS_ACC,
		BS_PD
	} base_t;

	typedef enum logic [2:0] {
		CD_NONE,
		CD_CLEAR,
		CD_PZERO,
		CD_UNPRIMED,
		CD_KEPT
	} cond_t;

	// One control word of the program.
	typedef struct packed {
		op_t op;
		tsel_t tsel;
		base_t base;
		logic save_pd;
		cond_t cond;
		step_t target;
		logic last;
	} ucw_t;

	// Datapath control for the current cycle.
	typedef struct packed {
		op_t op;
		tsel_t tsel;
		base_t base;
		logic save_pd;
	} ctl_t;

	// Status flags the sequencer branches on.
	typedef struct packed {
		logic clear_cmd;
		logic period_zero;
		logic primed;
		logic held;
		logic out_busy;
	} stat_t;

	localparam step_t SpAfterDeriv = 5'd4;
	localparam step_t SpOut = 5'd19;
	localparam step_t SpClr = 5'd20;
	localparam step_t SpDis = 5'd21;

	function automatic ucw_t mk(op_t op, tsel_t tsel, base_t base, logic save_pd,
			cond_t cond, step_t target, logic last);
		ucw_t w;
		w.op = op;
		w.tsel = tsel;
		w.base = base;
		w.save_pd = save_pd;
		w.cond = cond;
		w.target = target;
		w.last = last;
		return w;
	endfunction

	// The control program. Each gain term takes three steps: low partial
	// product, high partial product, then saturate and accumulate.
	function automatic ucw_t ucode(step_t s);
		ucw_t w;
		unique case (s)
			5'd0: w = mk(OP_ERR, TS_P, BS_ZERO, 1'b0, CD_CLEAR, SpClr, 1'b0);
			5'd1: w = mk(OP_DIFF, TS_P, BS_ZERO, 1'b0, CD_PZERO, SpDis, 1'b0);
			5'd2: w = mk(OP_MUL_DR, TS_P, BS_ZERO, 1'b0, CD_UNPRIMED, SpAfterDeriv, 1'b0);
			5'd3: w = mk(OP_DERIV, TS_P, BS_ZERO, 1'b0, CD_NONE, SpOut, 1'b0);
			5'd4: w = mk(OP_MUL_EP, TS_P, BS_ZERO, 1'b0, CD_NONE, SpOut, 1'b0);
			5'd5: w = mk(OP_CAND, TS_P, BS_ZERO, 1'b0, CD_NONE, SpOut, 1'b0);
			5'd6: w = mk(OP_MLO, TS_P, BS_ZERO, 1'b0, CD_NONE, SpOut, 1'b0);
			5'd7: w = mk(OP_MHI, TS_P, BS_ZERO, 1'b0, CD_NONE, SpOut, 1'b0);
			5'd8: w = mk(OP_ACC, TS_P, BS_ZERO, 1'b0, CD_NONE, SpOut, 1'b0);
			5'd9: w = mk(OP_MLO, TS_D, BS_ZERO, 1'b0, CD_NONE, SpOut, 1'b0);
			5'd10: w = mk(OP_MHI, TS_D, BS_ZERO, 1'b0, CD_NONE, SpOut, 1'b0);
			5'd11: w = mk(OP_ACC, TS_D, BS_ACC, 1'b1, CD_NONE, SpOut, 1'b0);
			5'd12: w = mk(OP_MLO, TS_I_CAND, BS_ZERO, 1'b0, CD_NONE, SpOut, 1'b0);
			5'd13: w = mk(OP_MHI, TS_I_CAND, BS_ZERO, 1'b0, CD_NONE, SpOut, 1'b0);
			5'd14: w = mk(OP_ACC, TS_I_CAND, BS_ACC, 1'b0, CD_NONE, SpOut, 1'b0);
			5'd15: w = mk(OP_HOLD, TS_P, BS_ZERO, 1'b0, CD_KEPT, SpOut, 1'b0);
			5'd16: w = mk(OP_MLO, TS_I_OLD, BS_ZERO, 1'b0, CD_NONE, SpOut, 1'b0);
			5'd17: w = mk(OP_MHI, TS_I_OLD, BS_ZERO, 1'b0, CD_NONE, SpOut, 1'b0);
			5'd18: w = mk(OP_ACC, TS_I_OLD, BS_PD, 1'b0, CD_NONE, SpOut, 1'b0);
			5'd19: w = mk(OP_OUT, TS_P, BS_ZERO, 1'b0, CD_NONE, SpOut, 1'b1);
			5'd20: w = mk(OP_CLR, TS_P, BS_ZERO, 1'b0, CD_NONE, SpOut, 1'b1);
			5'd21: w = mk(OP_DIS, TS_P, BS_ZERO, 1'b0, CD_NONE, SpOut, 1'b1);
			default: w = mk(OP_NOP, TS_P, BS_ZERO, 1'b0, CD_NONE, SpOut, 1'b1);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[rtl/ppid_seq.sv]
// Microcode sequencer: step counter, program lookup and conditional jumps.
// Depends on ppid_pkg.
`default_nettype none

module ppid_seq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire ppid_pkg::stat_t stat,
	output ppid_pkg::ctl_t      ctl
);

	logic busy_q;
	ppid_pkg::step_t step_q;
	ppid_pkg::ucw_t cw;
	logic needs_out;
	logic go;
	logic take;

	assign cw = ppid_pkg::ucode(step_q);
	assign needs_out = (cw.op == ppid_pkg::OP_OUT) || (cw.op == ppid_pkg::OP_DIS);
	// A step that writes the result register waits while the old result stalls.
	assign go = busy_q && !(needs_out && stat.out_busy);
	assign in_ready = !busy_q;

	always_comb begin
		unique case (cw.cond)
			ppid_pkg::CD_CLEAR: take = stat.clear_cmd;
			ppid_pkg::CD_PZERO: take = stat.period_zero;
			ppid_pkg::CD_UNPRIMED: take = !stat.primed;
			ppid_pkg::CD_KEPT: take = !stat.held;
			default: take = 1'b0;
		endcase
	end

	always_comb begin
		ctl.op = go ? cw.op : ppid_pkg::OP_NOP;
		ctl.tsel = cw.tsel;
		ctl.base = cw.base;
		ctl.save_pd = cw.save_pd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end
		end else if (go) begin
			step_q <= take ? cw.target : step_q + 1'b1;
			if (cw.last) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/ppid_dp.sv]
// Datapath: shared 32x32 multiplier, term accumulator, controller state and
// result register. Depends on ppid_pkg.
`default_nettype none

module ppid_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ppid_pkg::ctl_t  ctl,
	input  wire ppid_pkg::cfg_t  cfg,
	input  wire logic            cmd,
	input  wire logic [31:0]     sp,
	input  wire logic [31:0]     ms,
	input  wire logic            out_ready,
	output ppid_pkg::stat_t      stat,
	output logic                 out_valid,
	output logic [31:0]          drive,
	output logic                 integration_held,
	output logic                 output_limited,
	output logic                 loop_disabled
);

	// Controller state.
	logic signed [47:0] integ_q;
	logic [31:0] prev_q;
	logic primed_q;

	// Working registers of one item.
	logic [31:0] err_q;
	logic [31:0] diff_mag_q;
	logic diff_neg_q;
	logic [48:0] deriv_q;
	logic [47:0] cand_q;
	logic [63:0] prod_q;
	logic [47:0] plo_q;
	logic signed [62:0] acc_q;
	logic signed [62:0] pd_q;
	logic held_q;

	// Result register.
	logic out_valid_q;
	logic [31:0] drive_q;
	logic held_out_q;
	logic limited_q;
	logic disabled_q;

	logic [32:0] err_wide;
	logic [31:0] err_sat;
	logic [32:0] diff_wide;
	logic [32:0] diff_abs;
	logic [31:0] err_mag;
	logic [31:0] gain;
	logic [31:0] gain_mag;
	logic [48:0] opnd;
	logic [48:0] opnd_mag;
	logic term_neg;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [65:0] term_sum;
	logic [60:0] term_mag;
	logic [61:0] term_sv;
	logic [62:0] base_val;
	logic [62:0] acc_next;
	logic [49:0] inc_ext;
	logic [49:0] cand_raw;
	logic [49:0] bound_pos;
	logic [49:0] bound_neg;
	logic [47:0] cand_next;
	logic [48:0] deriv_mag;
	logic [62:0] dmax_w;
	logic [62:0] dmin_w;
	logic held;
	logic err_pos;

	// Error, saturated to the 32-bit signed range.
	always_comb begin
		err_wide = {sp[31], sp} - {ms[31], ms};
		if (err_wide[32] != err_wide[31]) begin
			err_sat = err_wide[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			err_sat = err_wide[31:0];
		end
	end

	assign diff_wide = {err_q[31], err_q} - {prev_q[31], prev_q};
	assign diff_abs = diff_wide[32] ? (~diff_wide + 33'd1) : diff_wide;
	assign err_mag = err_q[31] ? (~err_q + 32'd1) : err_q;
	assign err_pos = !err_q[31] && (err_q != 32'd0);

	// Gain and operand of the term being formed.
	always_comb begin
		unique case (ctl.tsel)
			ppid_pkg::TS_P: begin
				gain = cfg.gain_p;
				opnd = {{17{err_q[31]}}, err_q};
			end
			ppid_pkg::TS_I_CAND: begin
				gain = cfg.gain_i;
				opnd = {cand_q[47], cand_q};
			end
			ppid_pkg::TS_I_OLD: begin
				gain = cfg.gain_i;
				opnd = {integ_q[47], integ_q};
			end
			default: begin
				gain = cfg.gain_d;
				opnd = deriv_q;
			end
		endcase
		gain_mag = gain[31] ? (~gain + 32'd1) : gain;
		opnd_mag = opnd[48] ? (~opnd + 49'd1) : opnd;
		term_neg = gain[31] ^ opnd[48];
	end

	always_comb begin
		unique case (ctl.op)
			ppid_pkg::OP_MUL_DR: begin
				mul_a = diff_mag_q;
				mul_b = cfg.rate;
			end
			ppid_pkg::OP_MUL_EP: begin
				mul_a = err_mag;
				mul_b = cfg.period;
			end
			ppid_pkg::OP_MLO: begin
				mul_a = gain_mag;
				mul_b = opnd_mag[31:0];
			end
			ppid_pkg::OP_MHI: begin
				mul_a = gain_mag;
				mul_b = {15'd0, opnd_mag[48:32]};
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	// Term = (gain * operand) >> 16 on magnitudes, saturated to 2^60.
	always_comb begin
		term_sum = {1'b0, prod_q[48:0], 16'd0} + {18'd0, plo_q};
		term_mag = (term_sum > ppid_pkg::TermLimit) ? ppid_pkg::TermLimit[60:0] : term_sum[60:0];
		term_sv = term_neg ? (~{1'b0, term_mag} + 62'd1) : {1'b0, term_mag};
		unique case (ctl.base)
			ppid_pkg::BS_ACC: base_val = acc_q;
			ppid_pkg::BS_PD: base_val = pd_q;
			default: base_val = 63'd0;
		endcase
		acc_next = base_val + {term_sv[61], term_sv};
	end

	// Candidate integral, clamped to the symmetric bound.
	always_comb begin
		inc_ext = err_q[31] ? (~{18'd0, prod_q[63:32]} + 50'd1) : {18'd0, prod_q[63:32]};
		cand_raw = {{2{integ_q[47]}}, integ_q} + inc_ext;
		bound_pos = {3'd0, cfg.bound};
		bound_neg = ~bound_pos + 50'd1;
		if ($signed(cand_raw) > $signed(bound_pos)) begin
			cand_next = bound_pos[47:0];
		end else if ($signed(cand_raw) < $signed(bound_neg)) begin
			cand_next = bound_neg[47:0];
		end else begin
			cand_next = cand_raw[47:0];
		end
	end

	assign deriv_mag = {1'b0, prod_q[63:16]};
	assign dmax_w = {{31{cfg.drive_max[31]}}, cfg.drive_max};
	assign dmin_w = {{31{cfg.drive_min[31]}}, cfg.drive_min};
	assign held = (($signed(acc_q) > $signed(dmax_w)) && err_pos) ||
		(($signed(acc_q) < $signed(dmin_w)) && err_q[31]);

	always_comb begin
		stat.clear_cmd = cmd;
		stat.period_zero = (cfg.period == 32'd0);
		stat.primed = primed_q;
		stat.held = held;
		stat.out_busy = out_valid_q && !out_ready;
	end

	// Working registers carry no reset.
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			ppid_pkg::OP_ERR: err_q <= err_sat;
			ppid_pkg::OP_DIFF: begin
				diff_mag_q <= diff_abs[31:0];
				diff_neg_q <= diff_wide[32];
				deriv_q <= 49'd0;
			end
			ppid_pkg::OP_MUL_DR, ppid_pkg::OP_MUL_EP, ppid_pkg::OP_MLO: prod_q <= mul_a * mul_b;
			ppid_pkg::OP_MHI: begin
				plo_q <= prod_q[63:16];
				prod_q <= mul_a * mul_b;
			end
			ppid_pkg::OP_DERIV: deriv_q <= diff_neg_q ? (~deriv_mag + 49'd1) : deriv_mag;
			ppid_pkg::OP_CAND: cand_q <= cand_next;
			ppid_pkg::OP_ACC: begin
				acc_q <= acc_next;
				if (ctl.save_pd) begin
					pd_q <= acc_next;
				end
			end
			ppid_pkg::OP_HOLD: held_q <= held;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q <= '0;
			primed_q <= 1'b0;
		end else begin
			unique case (ctl.op)
				ppid_pkg::OP_HOLD: begin
					if (!held) begin
						integ_q <= cand_q;
					end
				end
				ppid_pkg::OP_OUT: begin
					prev_q <= err_q;
					primed_q <= 1'b1;
				end
				ppid_pkg::OP_CLR: begin
					integ_q <= '0;
					prev_q <= '0;
					primed_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((ctl.op == ppid_pkg::OP_OUT) || (ctl.op == ppid_pkg::OP_DIS)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == ppid_pkg::OP_OUT) begin
			held_out_q <= held_q;
			disabled_q <= 1'b0;
			if ($signed(acc_q) > $signed(dmax_w)) begin
				drive_q <= cfg.drive_max;
				limited_q <= 1'b1;
			end else if ($signed(acc_q) < $signed(dmin_w)) begin
				drive_q <= cfg.drive_min;
				limited_q <= 1'b1;
			end else begin
				drive_q <= acc_q[31:0];
				limited_q <= 1'b0;
			end
		end else if (ctl.op == ppid_pkg::OP_DIS) begin
			drive_q <= 32'd0;
			held_out_q <= 1'b0;
			limited_q <= 1'b0;
			disabled_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign drive = drive_q;
	assign integration_held = held_out_q;
	assign output_limited = limited_q;
	assign loop_disabled = disabled_q;

endmodule

`default_nettype wire

[rtl/positional_pid_antiwindup.sv]
// Top level of the positional PID controller with conditional-integration anti-windup.
// Holds the configuration registers and the input capture; depends on ppid_pkg,
// ppid_seq and ppid_dp.
//
// Usage:
//   Configuration is written through cfg_wen / cfg_index / cfg_data, one register
//   per cycle; the user writes it only while the block is idle, which the block
//   does not enforce. Indexes 0..7 select gain_p, gain_i, gain_d, sample_period,
//   sample_rate, drive_min, drive_max, integral_bound. Input items arrive on
//   in_valid / in_ready with command, setpoint, measured. A compute command yields
//   one result transfer on out_valid / out_ready; a clear command resets integral,
//   previous error and the primed flag and yields no result.
// Timing:
//   One item is in work at a time; in_ready is low from the transfer until the
//   last program step. A compute item takes 16 to 20 program steps (17 normally,
//   one less before the first derivative, three more when the integral is held);
//   in_ready returns high in the same cycle that the result appears, so the next
//   item can be taken then. All products share one 32x32 multiplier, so each
//   gain term needs two partial products and an accumulate step. A zero sample
//   period runs the error and difference steps and then the disable step; a
//   clear runs the error step and then the clear step.
//   The result sits in an output register; if the receiver stalls, the program
//   waits at its output step until that register drains.
// Reset:
//   arst_n clears the state, loads the default configuration and empties the
//   output register.
`default_nettype none

module positional_pid_antiwindup (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wen,
	input  wire logic [ppid_pkg::RegIdxW-1:0]    cfg_index,
	input  wire logic [ppid_pkg::CfgDataW-1:0]   cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            command,
	input  wire logic [31:0]                     setpoint,
	input  wire logic [31:0]                     measured,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [31:0]                          drive,
	output logic                                 integration_held,
	output logic                                 output_limited,
	output logic                                 loop_disabled
);

	ppid_pkg::cfg_t cfg_q;
	ppid_pkg::ctl_t ctl;
	ppid_pkg::stat_t stat;

	// Captured input item; it stays put while the program runs.
	logic cmd_q;
	logic [31:0] sp_q;
	logic [31:0] ms_q;

	// Configuration registers. The 32-bit registers keep only the low 32 bits of
	// the write data; the integral bound uses all 47.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p <= 32'd0;
			cfg_q.gain_i <= 32'd0;
			cfg_q.gain_d <= 32'd0;
			cfg_q.period <= 32'd0;
			cfg_q.rate <= 32'd0;
			cfg_q.drive_min <= ppid_pkg::DriveMinReset;
			cfg_q.drive_max <= ppid_pkg::DriveMaxReset;
			cfg_q.bound <= ppid_pkg::IntBoundReset;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				ppid_pkg::RegGainP: cfg_q.gain_p <= cfg_data[31:0];
				ppid_pkg::RegGainI: cfg_q.gain_i <= cfg_data[31:0];
				ppid_pkg::RegGainD: cfg_q.gain_d <= cfg_data[31:0];
				ppid_pkg::RegPeriod: cfg_q.period <= cfg_data[31:0];
				ppid_pkg::RegRate: cfg_q.rate <= cfg_data[31:0];
				ppid_pkg::RegDriveMin: cfg_q.drive_min <= cfg_data[31:0];
				ppid_pkg::RegDriveMax: cfg_q.drive_max <= cfg_data[31:0];
				ppid_pkg::RegIntBound: cfg_q.bound <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input transfer: the item is latched and the sequencer starts at step 0.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= command;
			sp_q <= setpoint;
			ms_q <= measured;
		end
	end

	ppid_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	ppid_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.cfg              (cfg_q),
		.cmd              (cmd_q),
		.sp               (sp_q),
		.ms               (ms_q),
		.out_ready        (out_ready),
		.stat             (stat),
		.out_valid        (out_valid),
		.drive            (drive),
		.integration_held (integration_held),
		.output_limited   (output_limited),
		.loop_disabled    (loop_disabled)
	);

endmodule

`default_nettype wire

[verif/positional_pid_antiwindup_tb.sv]
// Self-checking testbench for the positional PID block with anti-windup.
// Drives directed and random control items, predicts each drive result and compares.
// Depends on ppid_pkg and positional_pid_antiwindup from rtl/.

module positional_pid_antiwindup_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Item commands on the one-bit command field.
	localparam logic CmdCompute = 1'b0;
	localparam logic CmdClear = 1'b1;

	localparam logic [ppid_pkg::CfgDataW-1:0] DefaultIntegralLimit = 47'd6553600000;
	localparam logic [ppid_pkg::CfgDataW-1:0] MaxIntegralLimit = 47'h7FFF_FFFF_FFFF;
	localparam longint ErrMax = 64'sd2147483647;
	localparam longint ErrMin = -64'sd2147483648;
	localparam logic [127:0] TermCap = 128'd1 << 60;

	// This many quiet cycles after the last result are taken to mean that the
	// block has gone idle.
	localparam int IdleCycles = 25;
	localparam int WatchdogLimit = 2000;

	typedef struct packed {
		logic [31:0] drive;
		logic held;
		logic limited;
		logic disabled;
	} drive_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [ppid_pkg::RegIdxW-1:0] cfg_index = '0;
	logic [ppid_pkg::CfgDataW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic command = CmdCompute;
	logic [31:0] setpoint = '0;
	logic [31:0] measured = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] drive;
	logic integration_held;
	logic output_limited;
	logic loop_disabled;

	// Predicted configuration, kept as sign- or zero-extended integers.
	longint gain_p_q = 0;
	longint gain_i_q = 0;
	longint gain_d_q = 0;
	longint period_q = 0;
	longint rate_q = 0;
	longint drive_lo = ErrMin;
	longint drive_hi = ErrMax;
	longint integ_limit = longint'(DefaultIntegralLimit);

	// Predicted controller history.
	longint integ_sum = 0;
	longint prior_err = 0;
	bit primed_q = 1'b0;

	drive_result_t expected_drives[$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	// When set, neither side inserts idle cycles.
	bit steady_flow = 1'b0;

	positional_pid_antiwindup u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.setpoint(setpoint),
		.measured(measured),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive(drive),
		.integration_held(integration_held),
		.output_limited(output_limited),
		.loop_disabled(loop_disabled)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [127:0] magnitude(longint v);
		return (v < 0) ? 128'(-v) : 128'(v);
	endfunction

	// One gain term: the product of magnitudes, scaled down by 2^16 with
	// truncation toward zero and saturated at 2^60 before the sign returns.
	function automatic longint gain_term(longint gain, longint operand);
		logic [127:0] p;
		p = (magnitude(gain) * magnitude(operand)) >> 16;
		if (p > TermCap)
			p = TermCap;
		return ((gain < 0) != (operand < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	// Register writes land in the predicted configuration. The 32-bit
	// registers only keep the low word of the data.
	function automatic void apply_reg(logic [ppid_pkg::RegIdxW-1:0] idx,
			logic [ppid_pkg::CfgDataW-1:0] data);
		case (idx)
			ppid_pkg::RegGainP: gain_p_q = longint'($signed(data[31:0]));
			ppid_pkg::RegGainI: gain_i_q = longint'($signed(data[31:0]));
			ppid_pkg::RegGainD: gain_d_q = longint'($signed(data[31:0]));
			ppid_pkg::RegPeriod: period_q = longint'(data[31:0]);
			ppid_pkg::RegRate: rate_q = longint'(data[31:0]);
			ppid_pkg::RegDriveMin: drive_lo = longint'($signed(data[31:0]));
			ppid_pkg::RegDriveMax: drive_hi = longint'($signed(data[31:0]));
			ppid_pkg::RegIntBound: integ_limit = longint'(data);
			default: ;
		endcase
	endfunction

	// Advances the predicted controller by one accepted item. Returns 1 when
	// the item produces a drive result, which is then placed in res.
	function automatic bit predict_control_step(input logic cmd, input logic [31:0] sp,
			input logic [31:0] ms, output drive_result_t res);
		longint err, diff, deriv, cand, total, drv;
		logic [127:0] m;
		bit held, limited;
		res = '0;
		if (cmd == CmdClear) begin
			integ_sum = 0;
			prior_err = 0;
			primed_q = 1'b0;
			return 1'b0;
		end
		// With no sample period the loop is off and the history is left alone.
		if (period_q == 0) begin
			res.disabled = 1'b1;
			return 1'b1;
		end

		err = longint'($signed(sp)) - longint'($signed(ms));
		if (err > ErrMax)
			err = ErrMax;
		else if (err < ErrMin)
			err = ErrMin;

		// The derivative needs a previous error, so it is zero right after a clear.
		deriv = 0;
		if (primed_q) begin
			diff = err - prior_err;
			m = (magnitude(diff) * 128'(rate_q)) >> 16;
			deriv = (diff < 0) ? -longint'(m[63:0]) : longint'(m[63:0]);
		end

		m = (magnitude(err) * 128'(period_q)) >> 32;
		cand = integ_sum + ((err < 0) ? -longint'(m[63:0]) : longint'(m[63:0]));
		if (cand > integ_limit)
			cand = integ_limit;
		if (cand < -integ_limit)
			cand = -integ_limit;

		// Conditional integration: the new integral is dropped when the output
		// would already be past a bound and the error pushes further out.
		total = gain_term(gain_p_q, err) + gain_term(gain_i_q, cand) +
			gain_term(gain_d_q, deriv);
		held = (total > drive_hi && err > 0) || (total < drive_lo && err < 0);
		if (!held)
			integ_sum = cand;

		total = gain_term(gain_p_q, err) + gain_term(gain_i_q, integ_sum) +
			gain_term(gain_d_q, deriv);
		// The upper bound is tested first, which matters when the bounds cross.
		drv = total;
		limited = 1'b0;
		if (drv > drive_hi) begin
			drv = drive_hi;
			limited = 1'b1;
		end else if (drv < drive_lo) begin
			drv = drive_lo;
			limited = 1'b1;
		end

		prior_err = err;
		primed_q = 1'b1;
		res.drive = drv[31:0];
		res.held = held;
		res.limited = limited;
		return 1'b1;
	endfunction

	// Idle stretch length: mostly short, now and then a long one.
	function automatic int pause_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] corner_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4: return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	// Offers one item and waits for its transfer. The prediction is made at
	// the accepting edge, so the store of expected drives stays in order.
	task automatic send_item(logic cmd, logic [31:0] sp, logic [31:0] ms);
		int gap;
		drive_result_t res;
		gap = (steady_flow || $urandom_range(0, 1) == 0) ? 0 : pause_length();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		command <= cmd;
		setpoint <= sp;
		measured <= ms;
		do @(posedge clk); while (!in_ready);
		if (predict_control_step(cmd, sp, ms, res))
			expected_drives.push_back(res);
	endtask

	// Stops sending, waits for every expected drive, then lets the block
	// finish whatever item may still be in work.
	task automatic wait_for_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_drives.size() != 0) @(posedge clk);
		repeat (IdleCycles) @(posedge clk);
	endtask

	task automatic write_reg(logic [ppid_pkg::RegIdxW-1:0] idx,
			logic [ppid_pkg::CfgDataW-1:0] data);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Writes all eight registers. The 32-bit registers get random junk in the
	// upper data bits, which the block must ignore.
	task automatic program_loop(logic [31:0] kp, ki, kd, per, rt, lo, hi,
			logic [ppid_pkg::CfgDataW-1:0] lim);
		write_reg(ppid_pkg::RegGainP, {15'($urandom), kp});
		write_reg(ppid_pkg::RegGainI, {15'($urandom), ki});
		write_reg(ppid_pkg::RegGainD, {15'($urandom), kd});
		write_reg(ppid_pkg::RegPeriod, {15'($urandom), per});
		write_reg(ppid_pkg::RegRate, {15'($urandom), rt});
		write_reg(ppid_pkg::RegDriveMin, {15'($urandom), lo});
		write_reg(ppid_pkg::RegDriveMax, {15'($urandom), hi});
		write_reg(ppid_pkg::RegIntBound, lim);
	endtask

	// Out of reset the sample period is zero, so every compute item must
	// report a disabled loop with a zero drive.
	task automatic test_loop_disabled();
		send_item(CmdCompute, 32'h7FFF_FFFF, 32'h8000_0000);
		send_item(CmdCompute, $urandom, $urandom);
		send_item(CmdClear, $urandom, $urandom);
		send_item(CmdCompute, 32'h0001_0000, 32'h0000_0000);
		wait_for_idle();
	endtask

	// A 1 kHz loop with moderate gains, fed with errors that saturate the
	// 32-bit difference in both directions and with first samples after clears.
	task automatic test_error_extremes();
		program_loop(32'h0001_0000, 32'h0000_8000, 32'h0000_028F, 32'd4294967,
			32'd1000 << 16, 32'h8000_0000, 32'h7FFF_FFFF, DefaultIntegralLimit);
		send_item(CmdClear, 32'h0, 32'h0);
		send_item(CmdCompute, 32'h7FFF_FFFF, 32'h8000_0000);
		send_item(CmdCompute, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(CmdCompute, 32'h0000_0000, 32'h0000_0000);
		send_item(CmdCompute, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(CmdClear, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(CmdCompute, 32'h0001_0000, 32'h0000_0000);
		wait_for_idle();
	endtask

	// A huge integral gain makes the output run past its bounds, so the
	// integral is held in both directions. The second setting uses a tight
	// integral limit so the running sum clamps on either side.
	task automatic test_windup_hold();
		program_loop(32'h0001_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0,
			32'hFFF6_0000, 32'h000A_0000, MaxIntegralLimit);
		send_item(CmdClear, 32'h0, 32'h0);
		send_item(CmdCompute, 32'h0005_0000, 32'h0000_0000);
		send_item(CmdCompute, 32'h0005_0000, 32'h0000_0000);
		send_item(CmdCompute, 32'h0000_0000, 32'h0005_0000);
		send_item(CmdCompute, 32'h0000_0001, 32'h0000_0000);
		wait_for_idle();
		program_loop(32'h0, 32'h0001_0000, 32'h0, 32'hFFFF_FFFF, 32'd1000 << 16,
			32'h8000_0000, 32'h7FFF_FFFF, 47'h3_0000);
		send_item(CmdCompute, 32'h0064_0000, 32'h0000_0000);
		send_item(CmdCompute, 32'h0064_0000, 32'h0000_0000);
		send_item(CmdCompute, 32'h0000_0000, 32'h0064_0000);
		wait_for_idle();
	endtask

	// Lower bound above the upper one: anything above the upper bound takes
	// it, and only values that are not above it can fall to the lower one.
	task automatic test_crossed_bounds();
		program_loop(32'h0001_0000, 32'h0, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
			32'h0005_0000, 32'hFFFB_0000, DefaultIntegralLimit);
		send_item(CmdClear, 32'h0, 32'h0);
		send_item(CmdCompute, 32'h0064_0000, 32'h0000_0000);
		send_item(CmdCompute, 32'h0000_0000, 32'h0064_0000);
		send_item(CmdCompute, 32'h0000_0000, 32'h0000_0000);
		send_item(CmdCompute, 32'hFF9C_0000, 32'h0000_0000);
		wait_for_idle();
	endtask

	// Picks a new setting between phases. Most are plausible loops, so the
	// output moves inside its bounds and the integral does real work; the
	// rest are corner settings, crossed bounds and a disabled loop.
	task automatic randomize_loop_config();
		int kind, hz;
		logic [31:0] kp, ki, kd, per, rt, lo, hi;
		logic [ppid_pkg::CfgDataW-1:0] lim;
		kind = $urandom_range(0, 9);
		hz = $urandom_range(50, 20000);
		per = 32'hFFFF_FFFF / 32'(hz);
		rt = 32'(hz) << 16;
		kp = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
		ki = 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
		kd = 32'($urandom_range(0, 32'h0000_8000)) - 32'h0000_4000;
		lo = -32'($urandom_range(1, 32'h0400_0000));
		hi = 32'($urandom_range(1, 32'h0400_0000));
		lim = ($urandom_range(0, 1) == 0) ? 47'($urandom_range(0, 32'h1000_0000))
			: DefaultIntegralLimit;
		if (kind == 6 || kind == 7) begin
			kp = corner_word();
			ki = corner_word();
			kd = corner_word();
			per = corner_word();
			rt = corner_word();
			lo = corner_word();
			hi = corner_word();
			case ($urandom_range(0, 2))
				0: lim = '0;
				1: lim = MaxIntegralLimit;
				default: lim = 47'({$urandom, $urandom});
			endcase
		end else if (kind == 8) begin
			lo = -lo;
			hi = -hi;
		end else if (kind == 9) begin
			per = '0;
		end
		program_loop(kp, ki, kd, per, rt, lo, hi, lim);
	endtask

	// Phases of random traffic, each under a fresh setting. Most items track
	// a slowly moving target with small errors; some are full-range words or
	// corners, and a few are clears.
	task automatic test_random_operation();
		logic cmd;
		logic [31:0] sp, ms, target;
		int count;
		target = '0;
		for (int phase = 0; phase < 20; phase++) begin
			wait_for_idle();
			randomize_loop_config();
			steady_flow = (phase % 5 == 2);
			count = $urandom_range(65, 100);
			repeat (count) begin
				if ($urandom_range(0, 149) == 0)
					wait_for_idle();
				if ($urandom_range(0, 15) == 0)
					target = 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
				cmd = ($urandom_range(0, 99) < 5) ? CmdClear : CmdCompute;
				case ($urandom_range(0, 9))
					0: begin
						sp = $urandom;
						ms = $urandom;
					end
					1: begin
						sp = corner_word();
						ms = corner_word();
					end
					default: begin
						sp = target + 32'($urandom_range(0, 32'h0000_4000)) - 32'h0000_2000;
						ms = sp - (32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000);
					end
				endcase
				send_item(cmd, sp, ms);
			end
		end
		steady_flow = 1'b0;
	endtask

	// The receiver stalls at random: mostly short pauses, a few long ones,
	// and none at all while steady flow is on.
	initial begin : receiver_stalls
		int hold;
		hold = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
				if (!steady_flow && $urandom_range(0, 3) == 0)
					hold = pause_length();
			end
		end
	end

	// Every result transfer is compared field by field with the oldest
	// expected drive.
	always @(posedge clk) begin : check_results
		drive_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_drives.size() == 0) begin
				$display("%0t: result expected none, actual drive %h", $time, drive);
				mismatch_count++;
			end else begin
				want = expected_drives.pop_front();
				if (drive !== want.drive) begin
					$display("%0t: drive expected %h, actual %h", $time, want.drive, drive);
					mismatch_count++;
				end
				if (integration_held !== want.held) begin
					$display("%0t: integration_held expected %b, actual %b", $time,
						want.held, integration_held);
					mismatch_count++;
				end
				if (output_limited !== want.limited) begin
					$display("%0t: output_limited expected %b, actual %b", $time,
						want.limited, output_limited);
					mismatch_count++;
				end
				if (loop_disabled !== want.disabled) begin
					$display("%0t: loop_disabled expected %b, actual %b", $time,
						want.disabled, loop_disabled);
					mismatch_count++;
				end
			end
		end
	end

	// The watchdog ends a run that has gone quiet on every port for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wen)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_loop_disabled();
		test_error_extremes();
		test_windup_hold();
		test_crossed_bounds();
		test_random_operation();
		wait_for_idle();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
